/* hdl/adm_pkg.sv */
// adm_pkg: types, register codes and fixed-point constants for the arcade drive mixer
`timescale 1ns / 1ps
`default_nettype none

package adm_pkg;

  // drive limits and servo pulse range
  localparam int MAX_SPEED = 928;
  localparam int PULSE_MIN = 544;
  localparam int PULSE_MAX = 2400;

  // field widths fixed by the interface
  localparam int RAW_W  = 8;
  localparam int GAIN_W = 8;
  localparam int TRIM_W = 11;
  localparam int DZ_W   = 7;
  localparam int PUL_W  = 12;

  // apb port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // shaped stick, gain product, mixed sum magnitude
  localparam int STK_W = 8;
  localparam int PRD_W = 17;
  localparam int SUM_W = PRD_W + 1;
  localparam int MAG_W = 17;

  // truncating divide by 100 as reciprocal multiply
  localparam int     D100_DEN   = 100;
  localparam int     D100_SH    = MAG_W + $clog2(D100_DEN);
  localparam longint D100_RECIP = ((longint'(1) <<< D100_SH) + longint'(D100_DEN) - 1)
                                  / longint'(D100_DEN);
  localparam int     D100_RW    = $clog2(D100_RECIP + 1);
  localparam int     D100_PW    = MAG_W + D100_RW;

  // largest mixed magnitude: full gain, full stick on both terms
  localparam int MIX_MAX = (2 * ((1 << GAIN_W) - 1) * 127) / D100_DEN;
  localparam int MIX_W   = $clog2(MIX_MAX + 1);

  // proportional limit divider: one quotient bit per stage
  localparam int QW    = $clog2(MAX_SPEED + 1);
  localparam int DVD_W = MIX_W + QW;

  // trim sum and clamped speed
  localparam int TRM_W = ((QW > MIX_W) ? QW : MIX_W) + 3;
  localparam int SPD_W = QW + 1;

  // linear speed to pulse map
  localparam int     MAP_NUM   = PULSE_MAX - PULSE_MIN;
  localparam int     MAP_DEN   = 2 * MAX_SPEED;
  localparam int     OFF_W     = $clog2(MAP_DEN + 1);
  localparam int     MAPN_W    = OFF_W + $clog2(MAP_NUM + 1);
  localparam int     MAP_SH    = MAPN_W + $clog2(MAP_DEN);
  localparam longint MAP_RECIP = ((longint'(1) <<< MAP_SH) + longint'(MAP_DEN) - 1)
                                 / longint'(MAP_DEN);
  localparam int     MAP_RW    = $clog2(MAP_RECIP + 1);
  localparam int     MAP_PW    = MAPN_W + MAP_RW;
  localparam int     PQ_W      = $clog2(MAP_NUM + 1);

  // pipeline stage positions
  localparam int ST_SHAPE = 0;
  localparam int ST_MUL   = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_REC   = 3;
  localparam int ST_DVD   = 4;
  localparam int ST_DIV0  = 5;
  localparam int ST_TRIM  = ST_DIV0 + QW;
  localparam int ST_MAP   = ST_TRIM + 1;
  localparam int ST_PUL   = ST_MAP + 1;
  localparam int ST_OUT   = ST_PUL + 1;
  localparam int NST      = ST_OUT + 1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TGAIN  = 3'd0,
    REG_SGAIN  = 3'd1,
    REG_LTRIM  = 3'd2,
    REG_RTRIM  = 3'd3,
    REG_CTRIM  = 3'd4,
    REG_DZONE  = 3'd5
  } cfg_reg_t;

  // request payloads
  typedef struct packed {
    logic [RAW_W-1:0] raw_throttle;
    logic [RAW_W-1:0] raw_steering;
  } adm_in_t;

  typedef struct packed {
    logic [PUL_W-1:0] left_pulse;
    logic [PUL_W-1:0] right_pulse;
    logic             moving;
  } adm_out_t;

  // one stage of the limit divider, both sides share the divisor
  typedef struct packed {
    logic [DVD_W-1:0] rem_l;
    logic [DVD_W-1:0] rem_r;
    logic [QW-1:0]    quo_l;
    logic [QW-1:0]    quo_r;
    logic [MIX_W-1:0] dsor;
    logic [MIX_W-1:0] mag_l;
    logic [MIX_W-1:0] mag_r;
    logic             neg_l;
    logic             neg_r;
    logic             scale;
  } div_stage_t;

endpackage

`default_nettype wire

/* hdl/arcade_drive_mixer_top.sv */
// arcade_drive_mixer_top: pipelined two-stick mixer from stick bytes to servo pulses
//
//   channel  direction  handshake                   payload
//   in_      request    in_valid / in_stall         adm_in_t  (raw throttle, raw steering)
//   out_     result     out_valid / out_stall       adm_out_t (left, right pulse, moving)
//   cfg      apb        psel penable pwrite pready  six registers at byte address 4*i
//
// one request enters per cycle while in_stall is low, and each passes through NST stages
// the pipeline depth is set mostly by the limit divider, one quotient bit per stage
// reset (rst_n low, synchronous) empties the pipeline and loads register defaults
// a stage holds while it and every stage after it are full and out_stall is high,
// so in_stall only rises with the whole pipeline full behind a stalled output
`timescale 1ns / 1ps
`default_nettype none

module arcade_drive_mixer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  adm_pkg::adm_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output adm_pkg::adm_out_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [adm_pkg::PADDR_W-1:0]     paddr,
  input  logic [adm_pkg::PDATA_W-1:0]     pwdata,
  output logic [adm_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import adm_pkg::*;

  // centre, clamp, dead zone and shift toward zero
  function automatic logic signed [STK_W-1:0] shape_stick(input logic [RAW_W-1:0] raw,
                                                          input logic [DZ_W-1:0] dz);
    logic signed [RAW_W:0] v;
    logic [DZ_W-1:0]       mag;
    logic [DZ_W-1:0]       res;
    v = $signed({1'b0, raw}) - 9'sd128;
    if (v == -9'sd128) v = -9'sd127;
    mag = (v < 0) ? DZ_W'(-v) : DZ_W'(v);
    if (mag < dz) res = '0;
    else res = mag - dz;
    shape_stick = (v < 0) ? -$signed({1'b0, res}) : $signed({1'b0, res});
  endfunction

  // one restoring step of both divisions
  function automatic div_stage_t div_step(input div_stage_t s, input int b);
    div_stage_t       o;
    logic [DVD_W:0]   dsh;
    o   = s;
    dsh = (DVD_W + 1)'(s.dsor) << b;
    if ({1'b0, s.rem_l} >= dsh) begin
      o.rem_l    = s.rem_l - DVD_W'(dsh);
      o.quo_l[b] = 1'b1;
    end
    if ({1'b0, s.rem_r} >= dsh) begin
      o.rem_r    = s.rem_r - DVD_W'(dsh);
      o.quo_r[b] = 1'b1;
    end
    return o;
  endfunction

  // pick limited or raw magnitude, apply sign and trim, clamp
  function automatic logic signed [SPD_W-1:0] trim_clamp(input logic [QW-1:0] quo,
                                                         input logic [MIX_W-1:0] mag,
                                                         input logic neg,
                                                         input logic scale,
                                                         input logic signed [TRIM_W-1:0] trim);
    logic [TRM_W-2:0]        m;
    logic signed [TRM_W-1:0] v;
    logic signed [TRM_W-1:0] lim;
    lim = TRM_W'(MAX_SPEED);
    m   = scale ? (TRM_W - 1)'(quo) : (TRM_W - 1)'(mag);
    v   = $signed({1'b0, m});
    if (neg) v = -v;
    v = v + TRM_W'(trim);
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    return SPD_W'(v);
  endfunction

  // centre trim applies only strictly inside the pulse range
  function automatic logic [PUL_W-1:0] centre_trim(input logic [PUL_W-1:0] p,
                                                   input logic signed [TRIM_W-1:0] ct);
    logic signed [PUL_W+1:0] q;
    q = $signed({2'b00, p}) + (PUL_W + 2)'(ct);
    if (q < PULSE_MAX && q > PULSE_MIN) return q[PUL_W-1:0];
    else return p;
  endfunction

  // configuration registers
  logic [GAIN_W-1:0]        tgain_r;
  logic [GAIN_W-1:0]        sgain_r;
  logic signed [TRIM_W-1:0] ltrim_r;
  logic signed [TRIM_W-1:0] rtrim_r;
  logic signed [TRIM_W-1:0] ctrim_r;
  logic [DZ_W-1:0]          dz_r;
  cfg_reg_t                 cfg_idx;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgain_r <= GAIN_W'(100);
      sgain_r <= GAIN_W'(100);
      ltrim_r <= '0;
      rtrim_r <= '0;
      ctrim_r <= '0;
      dz_r    <= DZ_W'(25);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TGAIN: tgain_r <= pwdata[GAIN_W-1:0];
        REG_SGAIN: sgain_r <= pwdata[GAIN_W-1:0];
        REG_LTRIM: ltrim_r <= $signed(pwdata[TRIM_W-1:0]);
        REG_RTRIM: rtrim_r <= $signed(pwdata[TRIM_W-1:0]);
        REG_CTRIM: ctrim_r <= $signed(pwdata[TRIM_W-1:0]);
        REG_DZONE: dz_r    <= pwdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (cfg_idx)
      REG_TGAIN: prdata = PDATA_W'(tgain_r);
      REG_SGAIN: prdata = PDATA_W'(sgain_r);
      REG_LTRIM: prdata = PDATA_W'(ltrim_r);
      REG_RTRIM: prdata = PDATA_W'(rtrim_r);
      REG_CTRIM: prdata = PDATA_W'(ctrim_r);
      REG_DZONE: prdata = PDATA_W'(dz_r);
      default:   prdata = '0;
    endcase
  end

  // valid bits and per-stage advance
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] stg_en;

  // a stage moves when it or some later stage has a hole, or the output drains
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      stg_en[k] = !out_stall || (((~vld_r) >> k) != '0);
    end
  end

  assign vld_nxt  = {vld_r[NST-2:0], in_valid};
  assign in_stall = !stg_en[ST_SHAPE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (stg_en[k]) vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // stage: stick shaping
  logic signed [STK_W-1:0] stk_t_r, stk_t_nxt;
  logic signed [STK_W-1:0] stk_s_r, stk_s_nxt;
  logic [RAW_W-1:0]        raw_t;

  always_comb begin
    raw_t     = (in_data.raw_throttle == '0) ? RAW_W'(1) : in_data.raw_throttle;
    stk_t_nxt = shape_stick(raw_t, dz_r);
    stk_s_nxt = shape_stick(in_data.raw_steering, dz_r);
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_SHAPE]) begin
      stk_t_r <= stk_t_nxt;
      stk_s_r <= stk_s_nxt;
    end
  end

  // stage: gain products
  logic signed [PRD_W-1:0] prd_t_r, prd_t_nxt;
  logic signed [PRD_W-1:0] prd_s_r, prd_s_nxt;

  always_comb begin
    prd_t_nxt = $signed(PRD_W'({1'b0, tgain_r})) * PRD_W'(stk_t_r);
    prd_s_nxt = $signed(PRD_W'({1'b0, sgain_r})) * PRD_W'(stk_s_r);
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_MUL]) begin
      prd_t_r <= prd_t_nxt;
      prd_s_r <= prd_s_nxt;
    end
  end

  // stage: sum and difference, split into sign and magnitude
  logic [MAG_W-1:0]        amag_l_r, amag_l_nxt;
  logic [MAG_W-1:0]        amag_r_r, amag_r_nxt;
  logic                    aneg_l_r, aneg_l_nxt;
  logic                    aneg_r_r, aneg_r_nxt;
  logic signed [SUM_W-1:0] sum_l, sum_r;

  always_comb begin
    sum_l      = SUM_W'(prd_t_r) + SUM_W'(prd_s_r);
    sum_r      = SUM_W'(prd_t_r) - SUM_W'(prd_s_r);
    aneg_l_nxt = sum_l[SUM_W-1];
    aneg_r_nxt = sum_r[SUM_W-1];
    amag_l_nxt = aneg_l_nxt ? MAG_W'(-sum_l) : MAG_W'(sum_l);
    amag_r_nxt = aneg_r_nxt ? MAG_W'(-sum_r) : MAG_W'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_SUM]) begin
      amag_l_r <= amag_l_nxt;
      amag_r_r <= amag_r_nxt;
      aneg_l_r <= aneg_l_nxt;
      aneg_r_r <= aneg_r_nxt;
    end
  end

  // stage: truncating divide by 100
  logic [MIX_W-1:0]   mix_l_r, mix_l_nxt;
  logic [MIX_W-1:0]   mix_r_r, mix_r_nxt;
  logic               mneg_l_r, mneg_r_r;
  logic [D100_PW-1:0] rec_l, rec_r;

  always_comb begin
    rec_l     = D100_PW'(amag_l_r) * D100_PW'(D100_RECIP);
    rec_r     = D100_PW'(amag_r_r) * D100_PW'(D100_RECIP);
    mix_l_nxt = rec_l[D100_SH +: MIX_W];
    mix_r_nxt = rec_r[D100_SH +: MIX_W];
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_REC]) begin
      mix_l_r  <= mix_l_nxt;
      mix_r_r  <= mix_r_nxt;
      mneg_l_r <= aneg_l_r;
      mneg_r_r <= aneg_r_r;
    end
  end

  // stage: limit check and divider operands
  div_stage_t       div_in_r, div_in_nxt;
  logic [MIX_W-1:0] mx;

  always_comb begin
    mx               = (mix_l_r > mix_r_r) ? mix_l_r : mix_r_r;
    div_in_nxt       = '0;
    div_in_nxt.rem_l = DVD_W'(mix_l_r) * DVD_W'(MAX_SPEED);
    div_in_nxt.rem_r = DVD_W'(mix_r_r) * DVD_W'(MAX_SPEED);
    div_in_nxt.dsor  = mx;
    div_in_nxt.mag_l = mix_l_r;
    div_in_nxt.mag_r = mix_r_r;
    div_in_nxt.neg_l = mneg_l_r;
    div_in_nxt.neg_r = mneg_r_r;
    div_in_nxt.scale = (DVD_W'(mx) > DVD_W'(MAX_SPEED));
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_DVD]) div_in_r <= div_in_nxt;
  end

  // stages: proportional limit divider
  div_stage_t div_r   [QW];
  div_stage_t div_nxt [QW];
  div_stage_t div_src [QW+1];

  always_comb begin
    div_src[0] = div_in_r;
    for (int j = 0; j < QW; j++) begin
      div_src[j+1] = div_r[j];
    end
    for (int j = 0; j < QW; j++) begin
      div_nxt[j] = div_step(div_src[j], QW - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      if (stg_en[ST_DIV0 + j]) div_r[j] <= div_nxt[j];
    end
  end

  // stage: side trims and speed clamp
  logic signed [SPD_W-1:0] spd_l_r, spd_l_nxt;
  logic signed [SPD_W-1:0] spd_r_r, spd_r_nxt;
  logic                    mov_r, mov_nxt;
  div_stage_t              dq;

  always_comb begin
    dq        = div_src[QW];
    spd_l_nxt = trim_clamp(dq.quo_l, dq.mag_l, dq.neg_l, dq.scale, ltrim_r);
    spd_r_nxt = trim_clamp(dq.quo_r, dq.mag_r, dq.neg_r, dq.scale, rtrim_r);
    mov_nxt   = (spd_l_nxt != '0) || (spd_r_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_TRIM]) begin
      spd_l_r <= spd_l_nxt;
      spd_r_r <= spd_r_nxt;
      mov_r   <= mov_nxt;
    end
  end

  // stage: offset speed times pulse span
  logic [MAPN_W-1:0]     mprd_l_r, mprd_l_nxt;
  logic [MAPN_W-1:0]     mprd_r_r, mprd_r_nxt;
  logic                  mov_map_r;
  logic signed [SPD_W:0] off_l, off_r;

  always_comb begin
    off_l      = (SPD_W + 1)'(spd_l_r) + (SPD_W + 1)'(MAX_SPEED);
    off_r      = (SPD_W + 1)'(spd_r_r) + (SPD_W + 1)'(MAX_SPEED);
    mprd_l_nxt = MAPN_W'(off_l[OFF_W-1:0]) * MAPN_W'(MAP_NUM);
    mprd_r_nxt = MAPN_W'(off_r[OFF_W-1:0]) * MAPN_W'(MAP_NUM);
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_MAP]) begin
      mprd_l_r  <= mprd_l_nxt;
      mprd_r_r  <= mprd_r_nxt;
      mov_map_r <= mov_r;
    end
  end

  // stage: divide by input span and add pulse base
  logic [PUL_W-1:0]  pul_l_r, pul_l_nxt;
  logic [PUL_W-1:0]  pul_r_r, pul_r_nxt;
  logic              mov_pul_r;
  logic [MAP_PW-1:0] mq_l, mq_r;

  always_comb begin
    mq_l      = MAP_PW'(mprd_l_r) * MAP_PW'(MAP_RECIP);
    mq_r      = MAP_PW'(mprd_r_r) * MAP_PW'(MAP_RECIP);
    pul_l_nxt = PUL_W'(mq_l[MAP_SH +: PQ_W]) + PUL_W'(PULSE_MIN);
    pul_r_nxt = PUL_W'(mq_r[MAP_SH +: PQ_W]) + PUL_W'(PULSE_MIN);
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_PUL]) begin
      pul_l_r   <= pul_l_nxt;
      pul_r_r   <= pul_r_nxt;
      mov_pul_r <= mov_map_r;
    end
  end

  // stage: centre trim into the output register
  adm_out_t out_r, out_nxt;

  always_comb begin
    out_nxt.left_pulse  = centre_trim(pul_l_r, ctrim_r);
    out_nxt.right_pulse = centre_trim(pul_r_r, ctrim_r);
    out_nxt.moving      = mov_pul_r;
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_OUT]) out_r <= out_nxt;
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // input only held back when the whole pipeline is full behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&vld_r)))
    else $error("input stalled with room in the pipeline");

  // a finished request reaches the output as soon as the output drains
  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_PUL] && !out_stall) |=> out_valid)
    else $error("request lost before the output register");

  // pulses stay inside the servo range
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.left_pulse >= PUL_W'(PULSE_MIN)
                   && out_data.left_pulse <= PUL_W'(PULSE_MAX)
                   && out_data.right_pulse >= PUL_W'(PULSE_MIN)
                   && out_data.right_pulse <= PUL_W'(PULSE_MAX)))
    else $error("pulse outside servo range");
`endif

endmodule

`default_nettype wire
